>>> hw/rtl/icl_pkg.sv
package icl_pkg;

   // entry index width carried on the channels and stored in the link memories
   localparam int IDX_W = 10;

   // default pool size
   localparam int ICL_ENTRIES = 1024;

   // operation selector codes
   localparam logic [1:0] KIND_APPEND = 2'd0;
   localparam logic [1:0] KIND_REMOVE = 2'd1;
   localparam logic [1:0] KIND_POP    = 2'd2;

   // decoded operation, latched at the input transfer
   typedef enum logic [2:0] {
      OP_NONE         = 3'd0,
      OP_APPEND_EMPTY = 3'd1,
      OP_APPEND       = 3'd2,
      OP_REMOVE       = 3'd3,
      OP_POP          = 3'd4
   } icl_op_type;

   typedef struct packed {
      logic [1:0]       kind;
      logic             head_valid;
      logic [IDX_W-1:0] head_index;
      logic [IDX_W-1:0] entry_index;
   } icl_req_type;

   typedef struct packed {
      logic             new_head_valid;
      logic [IDX_W-1:0] new_head_index;
      logic             popped_valid;
      logic [IDX_W-1:0] popped_index;
   } icl_rsp_type;

endpackage

>>> hw/rtl/icl_link_ram.sv
module icl_link_ram import icl_pkg::*; #(
   parameter int DEPTH = ICL_ENTRIES
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [IDX_W-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [IDX_W-1:0]         rd_data
);

   logic [IDX_W-1:0] mem [DEPTH];
   logic [IDX_W-1:0] rd_data_ff;

   // one write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // one registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/icl_seq.sv
module icl_seq import icl_pkg::*; #(
   parameter int ENTRIES = ICL_ENTRIES
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  icl_req_type                req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output icl_rsp_type                rsp_data,
   // shared read address for both link memories
   output logic                       link_rd_en,
   output logic [$clog2(ENTRIES)-1:0] link_rd_addr,
   input  logic [IDX_W-1:0]           next_rd_data,
   input  logic [IDX_W-1:0]           prev_rd_data,
   // next link write port
   output logic                       next_wr_en,
   output logic [$clog2(ENTRIES)-1:0] next_wr_addr,
   output logic [IDX_W-1:0]           next_wr_data,
   // prev link write port
   output logic                       prev_wr_en,
   output logic [$clog2(ENTRIES)-1:0] prev_wr_addr,
   output logic [IDX_W-1:0]           prev_wr_data
);

   localparam int AW   = $clog2(ENTRIES);
   localparam int WIDE = (AW > IDX_W) ? AW : IDX_W;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_LINK  = 4'b0010,
      ST_LINK2 = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   icl_op_type       op_ff, op_in;
   logic             hv_ff, hv_in;
   logic [IDX_W-1:0] h_ff, h_in;
   logic [IDX_W-1:0] e_ff, e_in;
   icl_rsp_type      res_ff, res_in;
   logic             rsp_valid_ff, rsp_valid_in;
   icl_rsp_type      rsp_data_ff, rsp_data_in;

   logic             accept;
   logic             head_ok;
   logic             entry_ok;
   icl_op_type       op_dec;
   logic [IDX_W-1:0] link_n;
   logic [IDX_W-1:0] link_p;

   // entry index to memory address
   function automatic logic [AW-1:0] to_addr(input logic [IDX_W-1:0] idx);
      logic [WIDE-1:0] wide_idx;
      wide_idx = WIDE'(idx);
      return wide_idx[AW-1:0];
   endfunction

   function automatic logic in_pool(input logic [IDX_W-1:0] idx);
      return 32'(idx) < 32'(ENTRIES);
   endfunction

   assign accept = req_valid && !req_stall;

   // operation decode at the input transfer
   always_comb begin
      head_ok  = !req_data.head_valid || in_pool(req_data.head_index);
      entry_ok = in_pool(req_data.entry_index);
      case (req_data.kind)
         KIND_APPEND: begin
            if (head_ok && entry_ok) begin
               op_dec = req_data.head_valid ? OP_APPEND : OP_APPEND_EMPTY;
            end else begin
               op_dec = OP_NONE;
            end
         end
         KIND_REMOVE: begin
            op_dec = (head_ok && entry_ok) ? OP_REMOVE : OP_NONE;
         end
         KIND_POP: begin
            op_dec = (head_ok && req_data.head_valid) ? OP_POP : OP_NONE;
         end
         default: begin
            op_dec = OP_NONE;
         end
      endcase
   end

   // link read issued at the transfer itself: remove reads the entry, others the head
   assign link_rd_en   = accept;
   assign link_rd_addr = to_addr((req_data.kind == KIND_REMOVE) ?
                                 req_data.entry_index : req_data.head_index);

   assign link_n = next_rd_data;
   assign link_p = prev_rd_data;

   // sequencer: read, ST_LINK and for append to a non-empty list ST_LINK2, then hand off to the output register
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      hv_in        = hv_ff;
      h_in         = h_ff;
      e_in         = e_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      next_wr_en   = 1'b0;
      next_wr_addr = '0;
      next_wr_data = '0;
      prev_wr_en   = 1'b0;
      prev_wr_addr = '0;
      prev_wr_data = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in    = op_dec;
               hv_in    = req_data.head_valid;
               h_in     = req_data.head_index;
               e_in     = req_data.entry_index;
               state_in = ST_LINK;
            end
         end
         ST_LINK: begin
            res_in                = '0;
            res_in.new_head_valid = hv_ff;
            res_in.new_head_index = hv_ff ? h_ff : '0;
            state_in              = ST_DONE;
            case (op_ff)
               OP_APPEND_EMPTY: begin
                  next_wr_en            = 1'b1;
                  next_wr_addr          = to_addr(e_ff);
                  next_wr_data          = e_ff;
                  prev_wr_en            = 1'b1;
                  prev_wr_addr          = to_addr(e_ff);
                  prev_wr_data          = e_ff;
                  res_in.new_head_valid = 1'b1;
                  res_in.new_head_index = e_ff;
               end
               OP_APPEND: begin
                  // link the entry after the tail
                  next_wr_en   = 1'b1;
                  next_wr_addr = to_addr(link_p);
                  next_wr_data = e_ff;
                  prev_wr_en   = 1'b1;
                  prev_wr_addr = to_addr(e_ff);
                  prev_wr_data = link_p;
                  state_in     = ST_LINK2;
               end
               OP_REMOVE: begin
                  if (link_n == e_ff) begin
                     res_in.new_head_valid = 1'b0;
                     res_in.new_head_index = '0;
                  end else begin
                     next_wr_en   = 1'b1;
                     next_wr_addr = to_addr(link_p);
                     next_wr_data = link_n;
                     prev_wr_en   = 1'b1;
                     prev_wr_addr = to_addr(link_n);
                     prev_wr_data = link_p;
                     if (hv_ff && (h_ff == e_ff)) begin
                        res_in.new_head_index = link_n;
                     end
                  end
               end
               OP_POP: begin
                  next_wr_en            = 1'b1;
                  next_wr_addr          = to_addr(link_p);
                  next_wr_data          = link_n;
                  prev_wr_en            = 1'b1;
                  prev_wr_addr          = to_addr(link_n);
                  prev_wr_data          = link_p;
                  res_in.popped_valid   = 1'b1;
                  res_in.popped_index   = h_ff;
                  res_in.new_head_valid = (link_n != h_ff);
                  res_in.new_head_index = (link_n != h_ff) ? link_n : '0;
               end
               default: begin
               end
            endcase
         end
         ST_LINK2: begin
            // close the ring from the entry back to the head
            next_wr_en   = 1'b1;
            next_wr_addr = to_addr(e_ff);
            next_wr_data = h_ff;
            prev_wr_en   = 1'b1;
            prev_wr_addr = to_addr(h_ff);
            prev_wr_data = e_ff;
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // operands and results
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      hv_ff       <= hv_in;
      h_ff        <= h_in;
      e_ff        <= e_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> hw/rtl/indexed_circular_list_engine.sv
// Indexed circular doubly linked list engine.
// Keeps next and prev links over a pool of ENTRIES entries; many circular lists
// share the pool and each list's head lives with the caller.
// Input channel (req_valid / req_stall / req_data): one transfer carries the
// operation (append at tail, remove entry, pop head), the current head and an
// entry index. Output channel (rsp_valid / rsp_stall / rsp_data): one transfer
// per input with the new head and, for pop, the popped entry.
// Remove, pop and append to an empty list pass through ST_LINK alone; append to a
// non-empty list also needs ST_LINK2, because each link memory has one write
// port and that append writes two links of each.
// One item is worked on at a time: req_stall is high from the transfer until the
// result is moved into the output register.
// A finished result waits in the output register while rsp_stall is high; the
// next item is taken meanwhile, but its result waits until the register frees.
// Reset clears the sequencer and the output valid; link contents are left as
// they are and hold nothing meaningful until written.
module indexed_circular_list_engine import icl_pkg::*; #(
   parameter int ENTRIES = ICL_ENTRIES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  icl_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output icl_rsp_type rsp_data
);

   localparam int AW = $clog2(ENTRIES);

   logic             link_rd_en;
   logic [AW-1:0]    link_rd_addr;
   logic [IDX_W-1:0] next_rd_data;
   logic [IDX_W-1:0] prev_rd_data;
   logic             next_wr_en;
   logic [AW-1:0]    next_wr_addr;
   logic [IDX_W-1:0] next_wr_data;
   logic             prev_wr_en;
   logic [AW-1:0]    prev_wr_addr;
   logic [IDX_W-1:0] prev_wr_data;

   // sequencer and result register
   icl_seq #(
      .ENTRIES (ENTRIES)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .link_rd_en   (link_rd_en),
      .link_rd_addr (link_rd_addr),
      .next_rd_data (next_rd_data),
      .prev_rd_data (prev_rd_data),
      .next_wr_en   (next_wr_en),
      .next_wr_addr (next_wr_addr),
      .next_wr_data (next_wr_data),
      .prev_wr_en   (prev_wr_en),
      .prev_wr_addr (prev_wr_addr),
      .prev_wr_data (prev_wr_data)
   );

   // successor links
   icl_link_ram #(
      .DEPTH (ENTRIES)
   ) u_next_ram (
      .clock   (clock),
      .wr_en   (next_wr_en),
      .wr_addr (next_wr_addr),
      .wr_data (next_wr_data),
      .rd_en   (link_rd_en),
      .rd_addr (link_rd_addr),
      .rd_data (next_rd_data)
   );

   // predecessor links
   icl_link_ram #(
      .DEPTH (ENTRIES)
   ) u_prev_ram (
      .clock   (clock),
      .wr_en   (prev_wr_en),
      .wr_addr (prev_wr_addr),
      .wr_data (prev_wr_data),
      .rd_en   (link_rd_en),
      .rd_addr (link_rd_addr),
      .rd_data (prev_rd_data)
   );

endmodule

>>> hw/rtl/icl_check.sv
module icl_check import icl_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input icl_rsp_type rsp_data
);

   // no result appears right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // block is busy in the cycle after an input transfer
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input taken again without a busy cycle");

   // empty new head reads as zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.new_head_valid) |-> (rsp_data.new_head_index == '0))
      else $error("empty list reports a nonzero head");

   // no popped entry reads as zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.popped_valid) |-> (rsp_data.popped_index == '0))
      else $error("popped index nonzero without a pop");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");

endmodule

bind indexed_circular_list_engine icl_check u_check (.*);

>>> tb/list_op_checker.sv
`timescale 1ns / 100ps

module list_op_checker import icl_pkg::*; #(
   parameter int ENTRIES = ICL_ENTRIES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  icl_req_type req_data,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  icl_rsp_type rsp_data,
   output int          mismatch_count,
   output int          results_owed
);

   // shadow link memories, only ever read where written before
   logic [IDX_W-1:0] next_of [ENTRIES];
   logic [IDX_W-1:0] prev_of [ENTRIES];

   // predicted results waiting for their transfer, oldest first
   icl_rsp_type owed_heads [$];
   int errors = 0;

   // one line per mismatch, quiet after the first hundred
   task automatic report_mismatch(input string msg);
      errors++;
      if (errors <= 100) begin
         $display("list check: %s at %0t ns", msg, $time);
      end
   endtask

   task automatic check_field(input string what, input int got, input int want);
      if (got != want) begin
         report_mismatch($sformatf("%s is %0d, expected %0d", what, got, want));
      end
   endtask

   // apply one list operation to the shadow links and work out its result
   task automatic apply_list_op(input icl_req_type rq, output icl_rsp_type rs);
      logic [IDX_W-1:0] succ;
      logic [IDX_W-1:0] pred;
      logic             head_ok;
      logic             entry_ok;
      head_ok  = !rq.head_valid || (int'(rq.head_index) < ENTRIES);
      entry_ok = int'(rq.entry_index) < ENTRIES;
      rs = '0;
      rs.new_head_valid = rq.head_valid;
      rs.new_head_index = rq.head_valid ? rq.head_index : '0;
      case (rq.kind)
         KIND_APPEND: begin
            if (head_ok && entry_ok) begin
               if (!rq.head_valid) begin
                  // first member links to itself
                  next_of[rq.entry_index] = rq.entry_index;
                  prev_of[rq.entry_index] = rq.entry_index;
                  rs.new_head_valid = 1'b1;
                  rs.new_head_index = rq.entry_index;
               end else begin
                  // splice between tail and head, head stays
                  pred = prev_of[rq.head_index];
                  next_of[pred]           = rq.entry_index;
                  prev_of[rq.entry_index] = pred;
                  next_of[rq.entry_index] = rq.head_index;
                  prev_of[rq.head_index]  = rq.entry_index;
               end
            end
         end
         KIND_REMOVE: begin
            if (head_ok && entry_ok) begin
               succ = next_of[rq.entry_index];
               pred = prev_of[rq.entry_index];
               if (succ == rq.entry_index) begin
                  // lone member, list empties whatever head came along
                  rs.new_head_valid = 1'b0;
                  rs.new_head_index = '0;
               end else begin
                  next_of[pred] = succ;
                  prev_of[succ] = pred;
                  if (rq.head_valid && rq.head_index == rq.entry_index) begin
                     rs.new_head_index = succ;
                  end
               end
            end
         end
         KIND_POP: begin
            if (head_ok && rq.head_valid) begin
               succ = next_of[rq.head_index];
               pred = prev_of[rq.head_index];
               rs.popped_valid = 1'b1;
               rs.popped_index = rq.head_index;
               if (succ == rq.head_index) begin
                  rs.new_head_valid = 1'b0;
                  rs.new_head_index = '0;
               end else begin
                  rs.new_head_index = succ;
               end
               next_of[pred] = succ;
               prev_of[succ] = pred;
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin : watch
      icl_rsp_type want;
      if (!reset) begin
         // result transfer against the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (owed_heads.size() == 0) begin
               report_mismatch("result transfer with nothing owed");
            end else begin
               want = owed_heads.pop_front();
               check_field("new_head_valid", int'(rsp_data.new_head_valid),
                           int'(want.new_head_valid));
               check_field("new_head_index", int'(rsp_data.new_head_index),
                           int'(want.new_head_index));
               check_field("popped_valid", int'(rsp_data.popped_valid),
                           int'(want.popped_valid));
               check_field("popped_index", int'(rsp_data.popped_index),
                           int'(want.popped_index));
            end
         end
         // request transfer: predict and queue
         if (req_valid && !req_stall) begin
            apply_list_op(req_data, want);
            owed_heads.push_back(want);
         end
      end
      results_owed   <= owed_heads.size();
      mismatch_count <= errors;
   end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;
   import icl_pkg::*;

   localparam int LISTS        = 4;
   localparam int LIST_CAP     = 24;
   localparam int HALF         = ICL_ENTRIES / 2;
   localparam int RANDOM_ITEMS = 1250;
   localparam int DRAIN_EVERY  = 300;
   localparam int CYCLE_LIMIT  = 500000;

   // selector code the block leaves undefined
   localparam logic [1:0] KIND_SPARE = 2'd3;

   typedef enum logic [1:0] {
      RX_OPEN,
      RX_LIGHT,
      RX_HEAVY,
      RX_RUNS
   } rx_mode_type;

   logic        clock;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   icl_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   icl_rsp_type rsp_data;
   int          mismatch_count;
   int          results_owed;

   // well-formed lists live in the lower half of the pool
   int member [LISTS][LIST_CAP];
   int length [LISTS];
   bit in_use [HALF];

   // upper half takes arbitrary and misused operations
   bit linked_once [ICL_ENTRIES];
   int upper_pool [HALF];
   int upper_count = 0;

   int burst_left  = 0;
   int cycle_count = 0;

   rx_mode_type rx_mode = RX_OPEN;
   int          rx_left = 0;

   indexed_circular_list_engine #(
      .ENTRIES (ICL_ENTRIES)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   list_op_checker #(
      .ENTRIES (ICL_ENTRIES)
   ) i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .results_owed   (results_owed)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // receiver stall pattern, mode picked anew each time rx_left runs out
   always @(posedge clock) begin
      if (rx_left == 0) begin
         rx_mode = rx_mode_type'($urandom_range(3, 0));
         rx_left = $urandom_range(300, 20);
      end else begin
         rx_left = rx_left - 1;
      end
      case (rx_mode)
         RX_OPEN:  rsp_stall <= 1'b0;
         RX_LIGHT: rsp_stall <= ($urandom_range(3, 0) == 0);
         RX_HEAVY: rsp_stall <= ($urandom_range(3, 0) != 0);
         default: begin
            if ($urandom_range(9, 0) == 0) rsp_stall <= !rsp_stall;
         end
      endcase
   end

   function automatic int any_index();
      return $urandom_range(ICL_ENTRIES - 1, 0);
   endfunction

   function automatic icl_req_type mk_req(logic [1:0] kind, logic hv, int h, int e);
      icl_req_type rq;
      rq.kind        = kind;
      rq.head_valid  = hv;
      rq.head_index  = h[IDX_W-1:0];
      rq.entry_index = e[IDX_W-1:0];
      return rq;
   endfunction

   // present one item in bursts with random gaps, return once transferred
   task automatic send_req(input icl_req_type rq);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(5, 0);
         burst_left = ($urandom_range(7, 0) == 0) ? $urandom_range(60, 20)
                                                  : $urandom_range(8, 1);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      // an append writes both links of its entry
      if (rq.kind == KIND_APPEND && !linked_once[rq.entry_index]) begin
         linked_once[rq.entry_index] = 1'b1;
         if (int'(rq.entry_index) >= HALF) begin
            upper_pool[upper_count] = int'(rq.entry_index);
            upper_count++;
         end
      end
      req_valid <= 1'b1;
      req_data  <= rq;
      do @(posedge clock); while (req_stall);
   endtask

   // hold off until every result is back
   task automatic drain_results();
      req_valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (results_owed != 0);
   endtask

   function automatic int free_entry();
      int e;
      do e = $urandom_range(HALF - 1, 0); while (in_use[e]);
      return e;
   endfunction

   function automatic int upper_pick();
      return upper_pool[$urandom_range(upper_count - 1, 0)];
   endfunction

   task automatic list_take(input int ln, input int pos);
      in_use[member[ln][pos]] = 1'b0;
      for (int i = pos; i < length[ln] - 1; i++) member[ln][i] = member[ln][i + 1];
      length[ln]--;
   endtask

   task automatic list_append(input int ln, input int e);
      send_req(mk_req(KIND_APPEND, length[ln] > 0,
                      length[ln] > 0 ? member[ln][0] : any_index(), e));
      member[ln][length[ln]] = e;
      length[ln]++;
      in_use[e] = 1'b1;
   endtask

   task automatic list_remove(input int ln, input int pos, input bit loose);
      logic hv;
      int   h;
      hv = 1'b1;
      h  = member[ln][0];
      // a lone member goes whatever head comes along
      if (loose && length[ln] == 1) begin
         hv = 1'($urandom_range(1, 0));
         h  = any_index();
      end
      send_req(mk_req(KIND_REMOVE, hv, h, member[ln][pos]));
      list_take(ln, pos);
   endtask

   task automatic list_pop(input int ln);
      send_req(mk_req(KIND_POP, length[ln] > 0,
                      length[ln] > 0 ? member[ln][0] : any_index(), any_index()));
      if (length[ln] > 0) list_take(ln, 0);
   endtask

   // one well-formed operation on a random list, kept short so it often empties
   task automatic list_step();
      int ln;
      int roll;
      ln   = $urandom_range(LISTS - 1, 0);
      roll = $urandom_range(99, 0);
      if (length[ln] == 0) begin
         if (roll < 75) list_append(ln, free_entry());
         else list_pop(ln);
      end else if (roll < 45 && length[ln] < LIST_CAP) begin
         list_append(ln, free_entry());
      end else if (roll < 75) begin
         list_remove(ln, $urandom_range(length[ln] - 1, 0), 1'($urandom_range(1, 0)));
      end else begin
         list_pop(ln);
      end
   endtask

   // arbitrary operation in the upper half, reading only links written before
   task automatic upper_step();
      int   pick;
      logic hv;
      pick = $urandom_range(2, 0);
      hv   = (upper_count > 0) && ($urandom_range(1, 0) == 1);
      if (pick == 1 && upper_count > 0) begin
         send_req(mk_req(KIND_REMOVE, 1'($urandom_range(1, 0)), upper_pick(),
                         upper_pick()));
      end else if (pick == 2) begin
         send_req(mk_req(KIND_POP, hv, hv ? upper_pick() : any_index(), any_index()));
      end else begin
         send_req(mk_req(KIND_APPEND, hv, hv ? upper_pick() : any_index(),
                         $urandom_range(ICL_ENTRIES - 1, HALF)));
      end
   endtask

   initial begin : stimulus
      int items_sent;
      int next_drain;
      int roll;
      items_sent = 0;
      next_drain = DRAIN_EVERY;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // pop of an empty list and undefined selectors at the field extremes
      send_req(mk_req(KIND_POP, 1'b0, ICL_ENTRIES - 1, ICL_ENTRIES - 1));
      send_req(mk_req(KIND_SPARE, 1'b1, ICL_ENTRIES - 1, ICL_ENTRIES - 1));
      send_req(mk_req(KIND_SPARE, 1'b0, 0, 0));
      // append to empty, then pop of a lone member
      list_append(0, 0);
      list_pop(0);
      // middle removal, head removal that moves the head on
      list_append(0, 0);
      list_append(0, 1);
      list_append(0, 2);
      list_remove(0, 1, 1'b0);
      list_remove(0, 0, 1'b0);
      // lone member removed with no head given
      send_req(mk_req(KIND_REMOVE, 1'b0, ICL_ENTRIES - 1, 2));
      list_take(0, 0);
      // pop of a longer list, tail removal
      list_append(1, HALF - 1);
      list_append(1, 5);
      list_append(1, 6);
      list_pop(1);
      list_remove(1, 1, 1'b0);
      list_remove(1, 0, 1'b1);
      // misuse in the upper half: double append, removal from the wrong list
      send_req(mk_req(KIND_APPEND, 1'b0, 0, ICL_ENTRIES - 1));
      send_req(mk_req(KIND_APPEND, 1'b1, ICL_ENTRIES - 1, HALF));
      send_req(mk_req(KIND_APPEND, 1'b1, ICL_ENTRIES - 1, HALF));
      send_req(mk_req(KIND_REMOVE, 1'b0, 0, HALF));
      send_req(mk_req(KIND_POP, 1'b1, ICL_ENTRIES - 1, 0));
      drain_results();

      // random mix: mostly well-formed lists, some misuse and noise
      while (items_sent < RANDOM_ITEMS) begin
         roll = $urandom_range(99, 0);
         if (roll < 75) begin
            list_step();
            items_sent++;
         end else if (roll < 92) begin
            upper_step();
            items_sent++;
         end else begin
            send_req(mk_req(KIND_SPARE, 1'($urandom_range(1, 0)), any_index(),
                            any_index()));
            items_sent++;
         end
         if (items_sent >= next_drain) begin
            drain_results();
            next_drain += DRAIN_EVERY;
         end
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && results_owed == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
